// ----- hw/rtl/alle_pkg.sv -----
`default_nettype none

package alle_pkg;

	localparam int ADDR_W = 6;
	localparam int DATA_W = 32;

	// Operation codes on the input port.
	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_ERASE  = 2'd1;
	localparam logic [1:0] FUNC_WALK   = 2'd2;
	localparam logic [1:0] FUNC_NONE   = 2'd3;

	// Classes assigned by the front end.
	localparam logic [1:0] KIND_INS = 2'd0;
	localparam logic [1:0] KIND_ERS = 2'd1;
	localparam logic [1:0] KIND_TRV = 2'd2;
	localparam logic [1:0] KIND_BAD = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_BAD   = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] value;
	} item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/array_linked_list_engine.sv -----
// Insert runs states INS, INS2 and RESULT; erase runs ERS and RESULT.
// Traverse: head read, then one beat per node per cycle if not stalled.
// One item is worked at a time; a 2-entry queue buffers items behind it.
// Rate is set by the single read and write port of each node memory.
// Asynchronous active-low reset leaves an empty list; no clearing pass.
`default_nettype none

module array_linked_list_engine
	import alle_pkg::*;
#(
	parameter int NODES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        func,
	input  wire logic [ADDR_W-1:0] node_addr,
	input  wire logic [DATA_W-1:0] value,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [DATA_W-1:0]      data_out,
	output logic [ADDR_W-1:0]      new_index,
	output logic [1:0]             status,
	output logic                   last
);

	item_t push_item, pop_item;
	logic  push, full, pop, nonempty;

	alle_front #(.NODES(NODES)) u_front (
		.func      (func),
		.node_addr (node_addr),
		.value     (value),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.q_full    (full),
		.q_push    (push),
		.q_item    (push_item)
	);

	alle_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.nonempty  (nonempty)
	);

	alle_back #(.NODES(NODES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (nonempty),
		.q_item    (pop_item),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_out  (data_out),
		.new_index (new_index),
		.status    (status),
		.last      (last)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/alle_front.sv -----
`default_nettype none

module alle_front
	import alle_pkg::*;
#(
	parameter int NODES = 64
) (
	input  wire logic [1:0]        func,
	input  wire logic [ADDR_W-1:0] node_addr,
	input  wire logic [DATA_W-1:0] value,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              q_full,
	output logic                   q_push,
	output item_t                  q_item
);

	logic in_range;

	assign in_range = (32'(node_addr) < NODES);
	assign in_stall = q_full;
	// An unused operation code is taken and dropped without entering the queue.
	assign q_push   = in_valid && !q_full && (func != FUNC_NONE);

	always_comb begin
		q_item.addr  = node_addr;
		q_item.value = value;
		unique case (func)
			FUNC_INSERT: q_item.kind = in_range ? KIND_INS : KIND_BAD;
			FUNC_ERASE:  q_item.kind = (in_range && node_addr != '0) ? KIND_ERS : KIND_BAD;
			FUNC_WALK:   q_item.kind = KIND_TRV;
			FUNC_NONE:   q_item.kind = KIND_BAD;
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/alle_fifo.sv -----
`default_nettype none

module alle_fifo
	import alle_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output item_t      pop_item,
	output logic       nonempty
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	item_t          slot_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop)      count_q <= count_q + CW'(1);
			else if (!push && pop) count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_item;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/alle_back.sv -----
`default_nettype none

module alle_back
	import alle_pkg::*;
#(
	parameter int NODES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire item_t             q_item,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [DATA_W-1:0]      data_out,
	output logic [ADDR_W-1:0]      new_index,
	output logic [1:0]             status,
	output logic                   last
);

	localparam int IW = $clog2(NODES);
	localparam int CW = $clog2(NODES + 1);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_INS      = 3'd1;
	localparam logic [2:0] S_INS2     = 3'd2;
	localparam logic [2:0] S_ERS      = 3'd3;
	localparam logic [2:0] S_RESULT   = 3'd4;
	localparam logic [2:0] S_TRV_HEAD = 3'd5;
	localparam logic [2:0] S_TRV      = 3'd6;

	logic [DATA_W-1:0] value_mem [NODES];
	logic [IW-1:0]     next_mem  [NODES];
	logic [IW-1:0]     prev_mem  [NODES];

	logic [2:0]        state_q, state_d;
	logic [NODES-1:0]  live_q;
	logic [CW-1:0]     next_free_q;
	logic              head_set_q;
	logic              rd_blank_q;
	logic [DATA_W-1:0] value_rd_q;
	logic [IW-1:0]     next_rd_q;
	logic [IW-1:0]     prev_rd_q;

	logic [IW-1:0]     addr_q, addr_d;
	logic [DATA_W-1:0] value_q, value_d;
	logic [IW-1:0]     cur_q, cur_d;
	logic [CW-1:0]     k_q, k_d;
	logic [1:0]        res_st_q, res_st_d;
	logic [IW-1:0]     res_idx_q, res_idx_d;

	logic              out_valid_q;
	logic [DATA_W-1:0] data_out_q;
	logic [ADDR_W-1:0] new_index_q;
	logic [1:0]        status_q;
	logic              last_q;

	logic [IW-1:0]     rd_addr;
	logic              next_we, prev_we, value_we;
	logic [IW-1:0]     next_waddr, next_wdata, prev_waddr, prev_wdata;
	logic              live_set, live_clr, alloc;
	logic              emit, emit_last;
	logic [DATA_W-1:0] emit_data;
	logic [IW-1:0]     emit_idx;
	logic [1:0]        emit_st;

	logic              out_free, full, fin;
	logic [IW-1:0]     next_eff, nidx, q_idx;

	assign out_free = !out_valid_q || !out_stall;
	assign full     = (next_free_q >= CW'(NODES));
	assign nidx     = next_free_q[IW-1:0];
	assign q_idx    = q_item.addr[IW-1:0];
	// The head link is held at zero until its first write.
	assign next_eff = rd_blank_q ? '0 : next_rd_q;
	assign fin      = (next_eff == '0) || (32'(k_q) + 1 >= NODES - 1);

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		rd_addr    = cur_q;
		addr_d     = addr_q;
		value_d    = value_q;
		cur_d      = cur_q;
		k_d        = k_q;
		res_st_d   = res_st_q;
		res_idx_d  = res_idx_q;
		next_we    = 1'b0;
		next_waddr = nidx;
		next_wdata = '0;
		prev_we    = 1'b0;
		prev_waddr = nidx;
		prev_wdata = '0;
		value_we   = 1'b0;
		live_set   = 1'b0;
		live_clr   = 1'b0;
		alloc      = 1'b0;
		emit       = 1'b0;
		emit_data  = '0;
		emit_idx   = '0;
		emit_st    = ST_OK;
		emit_last  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					q_pop     = 1'b1;
					addr_d    = q_idx;
					value_d   = q_item.value;
					rd_addr   = q_idx;
					res_idx_d = '0;
					res_st_d  = ST_BAD;
					state_d   = S_RESULT;
					unique case (q_item.kind)
						KIND_INS: begin
							if (!live_q[q_idx]) begin
								res_st_d = ST_BAD;
							end else if (full) begin
								res_st_d = ST_FULL;
							end else begin
								state_d = S_INS;
							end
						end
						KIND_ERS: begin
							if (live_q[q_idx]) state_d = S_ERS;
						end
						KIND_TRV: begin
							rd_addr = '0;
							state_d = S_TRV_HEAD;
						end
						KIND_BAD: begin
							res_st_d = ST_BAD;
						end
					endcase
				end
			end
			S_INS: begin
				// New node takes the old successor and points back at the anchor.
				next_we    = 1'b1;
				next_waddr = nidx;
				next_wdata = next_eff;
				prev_we    = 1'b1;
				prev_waddr = nidx;
				prev_wdata = addr_q;
				value_we   = 1'b1;
				live_set   = 1'b1;
				cur_d      = next_eff;
				state_d    = S_INS2;
			end
			S_INS2: begin
				next_we    = 1'b1;
				next_waddr = addr_q;
				next_wdata = nidx;
				prev_we    = (cur_q != '0);
				prev_waddr = cur_q;
				prev_wdata = nidx;
				alloc      = 1'b1;
				res_st_d   = ST_OK;
				res_idx_d  = nidx;
				state_d    = S_RESULT;
			end
			S_ERS: begin
				next_we    = 1'b1;
				next_waddr = prev_rd_q;
				next_wdata = next_eff;
				prev_we    = (next_eff != '0);
				prev_waddr = next_eff;
				prev_wdata = prev_rd_q;
				live_clr   = 1'b1;
				res_st_d   = ST_OK;
				res_idx_d  = '0;
				state_d    = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					emit     = 1'b1;
					emit_idx = res_idx_q;
					emit_st  = res_st_q;
					state_d  = S_IDLE;
				end
			end
			S_TRV_HEAD: begin
				if (next_eff == '0) begin
					res_st_d  = ST_EMPTY;
					res_idx_d = '0;
					state_d   = S_RESULT;
				end else begin
					cur_d   = next_eff;
					rd_addr = next_eff;
					k_d     = '0;
					state_d = S_TRV;
				end
			end
			S_TRV: begin
				// While the output is blocked the current node is read again.
				if (out_free) begin
					emit      = 1'b1;
					emit_data = value_rd_q;
					emit_last = fin;
					if (fin) begin
						state_d = S_IDLE;
					end else begin
						cur_d   = next_eff;
						rd_addr = next_eff;
						k_d     = k_q + CW'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			live_q      <= NODES'(1);
			next_free_q <= CW'(1);
			head_set_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (live_set) live_q[nidx] <= 1'b1;
			if (live_clr) live_q[addr_q] <= 1'b0;
			if (alloc) next_free_q <= next_free_q + CW'(1);
			if (next_we && next_waddr == '0) head_set_q <= 1'b1;
			if (emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		addr_q     <= addr_d;
		value_q    <= value_d;
		cur_q      <= cur_d;
		k_q        <= k_d;
		res_st_q   <= res_st_d;
		res_idx_q  <= res_idx_d;
		rd_blank_q <= (rd_addr == '0) && !head_set_q;
		if (emit) begin
			data_out_q  <= emit_data;
			new_index_q <= ADDR_W'(emit_idx);
			status_q    <= emit_st;
			last_q      <= emit_last;
		end
	end

	always_ff @(posedge clk) begin
		if (value_we) value_mem[nidx] <= value_q;
		if (next_we)  next_mem[next_waddr] <= next_wdata;
		if (prev_we)  prev_mem[prev_waddr] <= prev_wdata;
		value_rd_q <= value_mem[rd_addr];
		next_rd_q  <= next_mem[rd_addr];
		prev_rd_q  <= prev_mem[rd_addr];
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign new_index = new_index_q;
	assign status    = status_q;
	assign last      = last_q;

	a_head_live: assert property (@(posedge clk) disable iff (!arst_n) live_q[0])
		else $error("head node lost its live bit");

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q != '0 && next_free_q <= CW'(NODES))
		else $error("allocator pointer out of range");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> last_q)
		else $error("error beat without last");

	a_idx_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && new_index_q != '0 |-> status_q == ST_OK)
		else $error("node index reported on a failed beat");

	a_alloc_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS2 |-> !full)
		else $error("insert went ahead on a full store");

endmodule

`default_nettype wire

// ----- bench/array_linked_list_engine_tb.sv -----
`timescale 1ns / 100ps

module array_linked_list_engine_tb;
	import alle_pkg::*;

	localparam int NODES = 64;
	localparam int HOLD_CYCLES = 200;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 20;
	localparam int SCRIPT_LEN = 23;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [ADDR_W-1:0] idx;
		logic [1:0]        st;
		logic              lst;
	} beat_t;

	typedef struct packed {
		logic [1:0]        f;
		logic [ADDR_W-1:0] a;
		logic [DATA_W-1:0] v;
		logic              typed;
		beat_t             want;
	} row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        func;
	logic [ADDR_W-1:0] node_addr;
	logic [DATA_W-1:0] value;
	logic              out_valid;
	logic              out_stall;
	logic [DATA_W-1:0] data_out;
	logic [ADDR_W-1:0] new_index;
	logic [1:0]        status;
	logic              last;

	// Shadow copy of the node memories and the allocator.
	logic [DATA_W-1:0] mem_val  [NODES];
	logic [ADDR_W-1:0] mem_prev [NODES];
	logic [ADDR_W-1:0] mem_next [NODES];
	bit                mem_live [NODES];
	logic [6:0]        alloc_ptr;

	beat_t step_beats [$];
	beat_t result_q   [$];
	row_t  script     [SCRIPT_LEN];

	int  errors = 0;
	int  snd_idle = 10;
	int  rcv_idle = 53;
	bit  hold_req = 1'b0;
	bit  hold_taken = 1'b0;

	array_linked_list_engine #(.NODES(NODES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.node_addr (node_addr),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_out  (data_out),
		.new_index (new_index),
		.status    (status),
		.last      (last)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic beat_t beat(logic [DATA_W-1:0] d, logic [ADDR_W-1:0] i,
			logic [1:0] s, logic l);
		beat_t b;
		b.data = d;
		b.idx = i;
		b.st = s;
		b.lst = l;
		return b;
	endfunction

	function automatic row_t op_row(logic [1:0] f, logic [ADDR_W-1:0] a,
			logic [DATA_W-1:0] v, logic typed, beat_t want);
		row_t r;
		r.f = f;
		r.a = a;
		r.v = v;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	// Applies one operation to the shadow list and collects the beats it yields.
	task automatic list_step(input logic [1:0] f, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] v);
		logic [ADDR_W-1:0] n;
		logic [ADDR_W-1:0] p;
		logic [ADDR_W-1:0] s;
		logic [ADDR_W-1:0] cur;
		int k;
		step_beats.delete();
		case (f)
			FUNC_INSERT: begin
				if (!mem_live[a]) begin
					step_beats.push_back(beat('0, '0, ST_BAD, 1'b1));
				end else if (alloc_ptr >= NODES) begin
					step_beats.push_back(beat('0, '0, ST_FULL, 1'b1));
				end else begin
					n = alloc_ptr[ADDR_W-1:0];
					s = mem_next[a];
					mem_val[n] = v;
					mem_prev[n] = a;
					mem_next[n] = s;
					mem_live[n] = 1'b1;
					if (s != 0)
						mem_prev[s] = n;
					mem_next[a] = n;
					alloc_ptr = alloc_ptr + 7'd1;
					step_beats.push_back(beat('0, n, ST_OK, 1'b1));
				end
			end
			FUNC_ERASE: begin
				if (a == 0 || !mem_live[a]) begin
					step_beats.push_back(beat('0, '0, ST_BAD, 1'b1));
				end else begin
					p = mem_prev[a];
					s = mem_next[a];
					mem_next[p] = s;
					if (s != 0)
						mem_prev[s] = p;
					mem_live[a] = 1'b0;
					step_beats.push_back(beat('0, '0, ST_OK, 1'b1));
				end
			end
			FUNC_WALK: begin
				cur = mem_next[0];
				k = 0;
				if (cur == 0) begin
					step_beats.push_back(beat('0, '0, ST_EMPTY, 1'b1));
				end else begin
					while (cur != 0 && k < NODES - 1) begin
						s = mem_next[cur];
						step_beats.push_back(beat(mem_val[cur], '0, ST_OK,
							s == 0 || k + 1 >= NODES - 1));
						k++;
						cur = s;
					end
				end
			end
			default: ;
		endcase
	endtask

	function automatic logic [ADDR_W-1:0] random_live(bit with_head);
		int pool [$];
		for (int i = 0; i < NODES; i++)
			if (mem_live[i] && (with_head || i != 0))
				pool.push_back(i);
		if (pool.size() == 0)
			return '0;
		return ADDR_W'(pool[$urandom_range(pool.size() - 1)]);
	endfunction

	task automatic send_item(input logic [1:0] f, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] v, input logic typed, input beat_t want);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		node_addr <= a;
		value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		list_step(f, a, v);
		if (typed)
			result_q.push_back(want);
		else
			foreach (step_beats[i])
				result_q.push_back(step_beats[i]);
	endtask

	task automatic send_random(input int count);
		int sent;
		int roll;
		bit full;
		logic [1:0] f;
		logic [ADDR_W-1:0] a;
		sent = 0;
		while (sent < count) begin
			roll = $urandom_range(99);
			full = alloc_ptr >= NODES;
			if (roll < 4) begin
				f = FUNC_NONE;
				a = ADDR_W'($urandom_range(NODES - 1));
			end else if (roll < (full ? 30 : 64)) begin
				f = FUNC_INSERT;
				a = ($urandom_range(9) == 0) ? ADDR_W'($urandom_range(NODES - 1))
					: random_live(1'b1);
			end else if (roll < (full ? 80 : 84)) begin
				f = FUNC_ERASE;
				a = ($urandom_range(9) == 0) ? ADDR_W'($urandom_range(NODES - 1))
					: random_live(1'b0);
			end else begin
				f = FUNC_WALK;
				a = ADDR_W'($urandom_range(NODES - 1));
			end
			send_item(f, a, $urandom, 1'b0, '0);
			// Ignored beats do not count toward the item budget.
			if (f != FUNC_NONE)
				sent++;
		end
	endtask

	initial begin : receiver
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < rcv_idle);
			end
		end
	end

	always @(posedge clk) begin : scoreboard
		beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				$error("unexpected result beat: data_out %h status %0d", data_out, status);
				errors++;
			end else begin
				want = result_q.pop_front();
				if (data_out !== want.data) begin
					$error("data_out: expected %h, got %h", want.data, data_out);
					errors++;
				end
				if (new_index !== want.idx) begin
					$error("new_index: expected %0d, got %0d", want.idx, new_index);
					errors++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					errors++;
				end
				if (last !== want.lst) begin
					$error("last: expected %0d, got %0d", want.lst, last);
					errors++;
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_NONE;
		node_addr = '0;
		value = '0;
		for (int i = 0; i < NODES; i++) begin
			mem_val[i] = '0;
			mem_prev[i] = '0;
			mem_next[i] = '0;
			mem_live[i] = (i == 0);
		end
		alloc_ptr = 7'd1;

		script[0]  = op_row(FUNC_WALK, 6'd0, 32'd0, 1'b1, beat('0, '0, ST_EMPTY, 1'b1));
		script[1]  = op_row(FUNC_ERASE, 6'd0, 32'd0, 1'b1, beat('0, '0, ST_BAD, 1'b1));
		script[2]  = op_row(FUNC_ERASE, 6'd5, 32'd0, 1'b1, beat('0, '0, ST_BAD, 1'b1));
		script[3]  = op_row(FUNC_INSERT, 6'd7, 32'd9, 1'b1, beat('0, '0, ST_BAD, 1'b1));
		script[4]  = op_row(FUNC_INSERT, 6'd0, 32'h7FFF_FFFF, 1'b1,
			beat('0, 6'd1, ST_OK, 1'b1));
		script[5]  = op_row(FUNC_INSERT, 6'd0, 32'h8000_0000, 1'b1,
			beat('0, 6'd2, ST_OK, 1'b1));
		script[6]  = op_row(FUNC_INSERT, 6'd1, 32'h0000_0000, 1'b0, '0);
		script[7]  = op_row(FUNC_INSERT, 6'd2, 32'hFFFF_FFFF, 1'b0, '0);
		script[8]  = op_row(FUNC_INSERT, 6'd63, 32'h1234_5678, 1'b1,
			beat('0, '0, ST_BAD, 1'b1));
		script[9]  = op_row(FUNC_WALK, 6'd0, 32'd0, 1'b0, '0);
		script[10] = op_row(FUNC_ERASE, 6'd1, 32'd0, 1'b1, beat('0, '0, ST_OK, 1'b1));
		script[11] = op_row(FUNC_ERASE, 6'd1, 32'd0, 1'b1, beat('0, '0, ST_BAD, 1'b1));
		script[12] = op_row(FUNC_INSERT, 6'd1, 32'd3, 1'b1, beat('0, '0, ST_BAD, 1'b1));
		script[13] = op_row(FUNC_NONE, 6'd63, 32'hFFFF_FFFF, 1'b0, '0);
		script[14] = op_row(FUNC_ERASE, 6'd2, 32'd0, 1'b0, '0);
		script[15] = op_row(FUNC_WALK, 6'd63, 32'd0, 1'b0, '0);
		script[16] = op_row(FUNC_ERASE, 6'd3, 32'd0, 1'b0, '0);
		script[17] = op_row(FUNC_ERASE, 6'd4, 32'd0, 1'b0, '0);
		script[18] = op_row(FUNC_WALK, 6'd0, 32'd0, 1'b1, beat('0, '0, ST_EMPTY, 1'b1));
		script[19] = op_row(FUNC_INSERT, 6'd0, 32'h5555_AAAA, 1'b0, '0);
		script[20] = op_row(FUNC_INSERT, 6'd5, 32'hAAAA_5555, 1'b0, '0);
		script[21] = op_row(FUNC_WALK, 6'd0, 32'd0, 1'b0, '0);
		script[22] = op_row(FUNC_ERASE, 6'd63, 32'd0, 1'b1, beat('0, '0, ST_BAD, 1'b1));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			send_item(script[i].f, script[i].a, script[i].v, script[i].typed, script[i].want);
		send_random(40);

		snd_idle = 53;
		rcv_idle = 10;
		send_random(45);

		// With no idling, a long receiver hold backs the block up into its input.
		snd_idle = 0;
		rcv_idle = 0;
		hold_req = 1'b1;
		send_random(50);
		in_valid <= 1'b0;

		while (result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/alle_pkg.sv
hw/rtl/alle_front.sv
hw/rtl/alle_fifo.sv
hw/rtl/alle_back.sv
hw/rtl/array_linked_list_engine.sv
bench/array_linked_list_engine_tb.sv
